### hdl/assert_macros.svh
// Assertion helper macros for the SD card SPI sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

### hdl/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// sdspi_pkg
// Types and constants shared by the SD card SPI host sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
package sdspi_pkg;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_READ = 2'd1,
    OP_BYTE = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    PH_IDLE, PH_SPIN_RST, PH_CMD0, PH_SPIN_IF, PH_CMD8, PH_IF_ECHO,
    PH_GAP_V2, PH_SPIN_V2, PH_CMD55, PH_GAP_41, PH_CMD41, PH_SPIN_41,
    PH_GAP_58, PH_CMD58, PH_OCR, PH_OCR_TAIL, PH_GAP_OLD, PH_CMD1,
    PH_SPIN_OLD, PH_GAP_OLD_OK, PH_CMD16, PH_END_SEL, PH_END_DESEL,
    PH_RD_PRE, PH_CMD17, PH_RD_POLL, PH_RD_DATA, PH_RD_TAIL_OK, PH_RD_TAIL_BAD
  } phase_e;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_OK   = 2'd1,
    ST_FAIL = 2'd2
  } status_e;

  // register indexes
  localparam logic [2:0] REG_RESET_ATT = 3'd0;
  localparam logic [2:0] REG_CMD1_ATT  = 3'd1;
  localparam logic [2:0] REG_ACMD41    = 3'd2;
  localparam logic [2:0] REG_V2_ROUNDS = 3'd3;
  localparam logic [2:0] REG_RESP_POLL = 3'd4;
  localparam logic [2:0] REG_TOK_POLL  = 3'd5;
  localparam logic [2:0] REG_SPIN      = 3'd6;

  localparam logic [7:0]  BYTE_IDLE   = 8'hFF;
  localparam logic [7:0]  DATA_TOKEN  = 8'hFE;
  localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS     = 32'h4000_0000;
  localparam logic [15:0] ECHO_PATTERN = 16'h01AA;

  typedef struct packed {
    logic [7:0]  reset_attempts;
    logic [7:0]  cmd1_attempts;
    logic [15:0] acmd41_attempts;
    logic [7:0]  v2_rounds;
    logic [15:0] response_polls;
    logic [20:0] token_polls;
    logic [7:0]  spin_bytes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] lba;
    logic [7:0]  rx_byte;
  } req_t;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        chip_select;
    logic        fast_clock;
    logic [31:0] data_word;
    logic        data_valid;
    logic        last_word;
    logic [1:0]  status;
    logic        card_is_sdhc;
  } rsp_t;

  // command frame code: CRC in [23:16], index in [7:0]
  function automatic logic [23:0] cmd_code(input phase_e ph);
    case (ph)
      PH_CMD0:  cmd_code = 24'h950040;
      PH_CMD1:  cmd_code = 24'hFF0041;
      PH_CMD17: cmd_code = 24'hFF0051;
      PH_CMD8:  cmd_code = 24'h870048;
      PH_CMD16: cmd_code = 24'hFF0050;
      PH_CMD41: cmd_code = 24'h870069;
      PH_CMD55: cmd_code = 24'hFF0077;
      PH_CMD58: cmd_code = 24'hFF007A;
      default:  cmd_code = 24'h000000;
    endcase
  endfunction

endpackage
`default_nettype wire

### hdl/sdspi_stream_if.sv
// ----------------------------------------------------------------------------
// sdspi_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none
interface sdspi_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/sdspi_cfg_regs.sv
// ----------------------------------------------------------------------------
// sdspi_cfg_regs
// Configuration register file; a zero spin length reads back as one.
// ----------------------------------------------------------------------------
`default_nettype none
module sdspi_cfg_regs (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [2:0]      cfg_index_i,
  input  wire logic [20:0]     cfg_data_i,
  output sdspi_pkg::cfg_t      cfg_o
);
  import sdspi_pkg::*;

  cfg_t regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.reset_attempts  <= 8'd6;
      regs_q.cmd1_attempts   <= 8'd19;
      regs_q.acmd41_attempts <= 16'd19999;
      regs_q.v2_rounds       <= 8'd48;
      regs_q.response_polls  <= 16'd40000;
      regs_q.token_polls     <= 21'd1499999;
      regs_q.spin_bytes      <= 8'd200;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_RESET_ATT: regs_q.reset_attempts  <= cfg_data_i[7:0];
        REG_CMD1_ATT:  regs_q.cmd1_attempts   <= cfg_data_i[7:0];
        REG_ACMD41:    regs_q.acmd41_attempts <= cfg_data_i[15:0];
        REG_V2_ROUNDS: regs_q.v2_rounds       <= cfg_data_i[7:0];
        REG_RESP_POLL: regs_q.response_polls  <= cfg_data_i[15:0];
        REG_TOK_POLL:  regs_q.token_polls     <= cfg_data_i;
        REG_SPIN:      regs_q.spin_bytes      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // only spin length treats zero as one; other compares behave the same
  always_comb begin
    cfg_o = regs_q;
    if (regs_q.spin_bytes == 8'd0) cfg_o.spin_bytes = 8'd1;
  end
endmodule
`default_nettype wire

### hdl/sdspi_core.sv
// ----------------------------------------------------------------------------
// sdspi_core
// One-pass sequencer step: request in, registered state update, combinational result out.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sdspi_core #(
  parameter int unsigned SECTOR_WORDS = 128
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sdspi_pkg::cfg_t cfg_i,
  input  wire logic            req_valid_i,
  input  wire sdspi_pkg::req_t req_i,
  output sdspi_pkg::rsp_t      rsp_o
);
  import sdspi_pkg::*;

  localparam int unsigned WIW = $clog2(SECTOR_WORDS + 1);

  phase_e          phase_q, phase_d;
  logic [15:0]     att_q, att_d;
  logic [7:0]      rnd_q, rnd_d;
  logic [20:0]     poll_q, poll_d;
  logic [7:0]      bidx_q, bidx_d;
  logic [WIW-1:0]  widx_q, widx_d;
  logic [31:0]     wasm_q, wasm_d;
  logic [31:0]     arg_q, arg_d;
  logic            sdhc_q, sdhc_d;
  rsp_t            r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      att_q   <= '0;
      rnd_q   <= '0;
      poll_q  <= '0;
      bidx_q  <= '0;
      widx_q  <= '0;
      wasm_q  <= '0;
      arg_q   <= '0;
      sdhc_q  <= 1'b0;
    end else if (req_valid_i) begin
      phase_q <= phase_d;
      att_q   <= att_d;
      rnd_q   <= rnd_d;
      poll_q  <= poll_d;
      bidx_q  <= bidx_d;
      widx_q  <= widx_d;
      wasm_q  <= wasm_d;
      arg_q   <= arg_d;
      sdhc_q  <= sdhc_d;
    end
  end

  // step logic
  always_comb begin
    logic [23:0] code;
    logic [23:0] nx_code;
    logic [7:0]  rx;
    logic [7:0]  flen;
    logic [15:0] att_inc;
    logic [7:0]  rnd_inc;
    logic [20:0] poll_inc;
    logic [31:0] shifted;
    logic [31:0] new_arg;
    logic        go_cmd;
    phase_e      cmd_ph;
    logic        go_fill;
    phase_e      fill_ph;
    logic        do_detect;
    logic        det_v;
    logic        do_finish;
    status_e     fin_st;

    phase_d = phase_q; att_d = att_q; rnd_d = rnd_q; poll_d = poll_q;
    bidx_d = bidx_q; widx_d = widx_q; wasm_d = wasm_q; arg_d = arg_q;
    sdhc_d = sdhc_q;
    r = '0;
    rx = req_i.rx_byte;
    code = cmd_code(phase_q);
    att_inc = att_q + 16'd1;
    rnd_inc = rnd_q + 8'd1;
    poll_inc = poll_q + 21'd1;
    shifted = (wasm_q << 8) | {24'd0, rx};
    go_cmd = 1'b0; cmd_ph = PH_IDLE; new_arg = '0;
    go_fill = 1'b0; fill_ph = PH_IDLE;
    do_detect = 1'b0; det_v = 1'b0;
    do_finish = 1'b0; fin_st = ST_BUSY;

    case (phase_q)
      PH_SPIN_RST, PH_SPIN_IF, PH_SPIN_V2, PH_SPIN_41, PH_SPIN_OLD:
        flen = cfg_i.spin_bytes;
      PH_IF_ECHO, PH_OCR_TAIL: flen = 8'd4;
      default: flen = 8'd1;
    endcase

    case (op_e'(req_i.operation))
      OP_INIT: begin
        att_d = '0; rnd_d = '0; poll_d = '0; widx_d = '0; arg_d = '0;
        sdhc_d = 1'b1;
        go_fill = 1'b1; fill_ph = PH_SPIN_RST;
      end
      OP_READ: begin
        arg_d = req_i.lba; poll_d = '0; widx_d = '0;
        go_fill = 1'b1; fill_ph = PH_RD_PRE;
      end
      OP_BYTE: begin
        if (phase_q != PH_IDLE) begin
          if (code != 24'd0) begin
            if (bidx_q < 8'd6) begin
              r.tx_valid = 1'b1;
              case (bidx_q)
                8'd1: r.tx_byte = arg_q[31:24];
                8'd2: r.tx_byte = arg_q[23:16];
                8'd3: r.tx_byte = arg_q[15:8];
                8'd4: r.tx_byte = arg_q[7:0];
                default: r.tx_byte = code[23:16];
              endcase
              bidx_d = bidx_q + 8'd1;
            end else if (rx == BYTE_IDLE &&
                         poll_inc < {5'd0, cfg_i.response_polls}) begin
              poll_d = poll_inc;
              r.tx_valid = 1'b1; r.tx_byte = BYTE_IDLE;
            end else begin
              // response handling
              case (phase_q)
                PH_CMD0: begin
                  if (rx == 8'd1) begin
                    go_fill = 1'b1; fill_ph = PH_SPIN_IF;
                  end else begin
                    att_d = att_inc;
                    if (att_inc >= {8'd0, cfg_i.reset_attempts}) begin
                      do_finish = 1'b1; fin_st = ST_FAIL;
                    end else begin
                      go_cmd = 1'b1; cmd_ph = PH_CMD0;
                    end
                  end
                end
                PH_CMD8: begin
                  go_fill = 1'b1; fill_ph = (rx == 8'd1) ? PH_IF_ECHO : PH_GAP_OLD;
                end
                PH_CMD55: begin
                  if (rx == 8'd1) begin
                    go_fill = 1'b1; fill_ph = PH_GAP_41;
                  end else begin
                    att_d = att_inc;
                    if (att_inc >= cfg_i.acmd41_attempts) begin
                      rnd_d = rnd_inc;
                      if (rnd_inc >= cfg_i.v2_rounds) do_detect = 1'b1;
                      else begin go_fill = 1'b1; fill_ph = PH_SPIN_V2; end
                    end else begin
                      go_cmd = 1'b1; cmd_ph = PH_CMD55;
                    end
                  end
                end
                PH_CMD41: begin
                  go_fill = 1'b1; fill_ph = (rx == 8'd0) ? PH_GAP_58 : PH_SPIN_41;
                end
                PH_CMD58: begin
                  if (rx == 8'd0) begin
                    go_fill = 1'b1; fill_ph = PH_OCR;
                  end else begin
                    rnd_d = rnd_inc;
                    if (rnd_inc >= cfg_i.v2_rounds) do_detect = 1'b1;
                    else begin go_fill = 1'b1; fill_ph = PH_SPIN_V2; end
                  end
                end
                PH_CMD1: begin
                  go_fill = 1'b1; fill_ph = (rx == 8'd0) ? PH_GAP_OLD_OK : PH_SPIN_OLD;
                end
                PH_CMD16: begin
                  go_fill = 1'b1; fill_ph = PH_END_SEL;
                end
                default: begin
                  if (rx == 8'd0) begin
                    phase_d = PH_RD_POLL; poll_d = '0;
                    r.tx_valid = 1'b1; r.tx_byte = BYTE_IDLE;
                  end else begin
                    do_finish = 1'b1; fin_st = ST_FAIL;
                  end
                end
              endcase
            end
          end else if (phase_q == PH_RD_POLL) begin
            if (rx == DATA_TOKEN) begin
              phase_d = PH_RD_DATA; bidx_d = '0; widx_d = '0; wasm_d = '0;
              r.tx_valid = 1'b1; r.tx_byte = BYTE_IDLE;
            end else begin
              poll_d = poll_inc;
              if (poll_inc >= cfg_i.token_polls) begin
                go_fill = 1'b1; fill_ph = PH_RD_TAIL_BAD;
              end else begin
                r.tx_valid = 1'b1; r.tx_byte = BYTE_IDLE;
              end
            end
          end else if (phase_q == PH_RD_DATA) begin
            wasm_d = shifted;
            if (bidx_q + 8'd1 >= 8'd4) begin
              r.data_valid = 1'b1; r.data_word = shifted;
              bidx_d = '0; widx_d = widx_q + WIW'(1);
              if ({{(32-WIW){1'b0}}, widx_q} + 32'd1 >= 32'(SECTOR_WORDS)) begin
                r.last_word = 1'b1; go_fill = 1'b1; fill_ph = PH_RD_TAIL_OK;
              end else begin
                r.tx_valid = 1'b1; r.tx_byte = BYTE_IDLE;
              end
            end else begin
              bidx_d = bidx_q + 8'd1;
              r.tx_valid = 1'b1; r.tx_byte = BYTE_IDLE;
            end
          end else begin
            wasm_d = shifted;
            if (bidx_q < flen) begin
              bidx_d = bidx_q + 8'd1;
              r.tx_valid = 1'b1; r.tx_byte = BYTE_IDLE;
            end else begin
              case (phase_q)
                PH_SPIN_RST: begin att_d = '0; go_cmd = 1'b1; cmd_ph = PH_CMD0; end
                PH_SPIN_IF: begin go_cmd = 1'b1; cmd_ph = PH_CMD8; new_arg = ARG_IF_COND; end
                PH_IF_ECHO: begin
                  go_fill = 1'b1;
                  fill_ph = (shifted[15:0] == ECHO_PATTERN) ? PH_GAP_V2 : PH_GAP_OLD;
                end
                PH_GAP_V2: begin rnd_d = '0; go_fill = 1'b1; fill_ph = PH_SPIN_V2; end
                PH_SPIN_V2: begin att_d = '0; go_cmd = 1'b1; cmd_ph = PH_CMD55; end
                PH_GAP_41: begin go_cmd = 1'b1; cmd_ph = PH_CMD41; new_arg = ARG_HCS; end
                PH_SPIN_41: begin
                  att_d = att_inc;
                  if (att_inc >= cfg_i.acmd41_attempts) begin
                    rnd_d = rnd_inc;
                    if (rnd_inc >= cfg_i.v2_rounds) do_detect = 1'b1;
                    else begin go_fill = 1'b1; fill_ph = PH_SPIN_V2; end
                  end else begin
                    go_cmd = 1'b1; cmd_ph = PH_CMD55;
                  end
                end
                PH_GAP_58: begin go_cmd = 1'b1; cmd_ph = PH_CMD58; end
                PH_OCR: begin
                  sdhc_d = rx[6]; go_fill = 1'b1; fill_ph = PH_OCR_TAIL;
                end
                PH_OCR_TAIL: begin do_detect = 1'b1; det_v = sdhc_q; end
                PH_GAP_OLD: begin att_d = '0; go_cmd = 1'b1; cmd_ph = PH_CMD1; end
                PH_SPIN_OLD: begin
                  att_d = att_inc;
                  if (att_inc >= {8'd0, cfg_i.cmd1_attempts}) do_detect = 1'b1;
                  else begin go_cmd = 1'b1; cmd_ph = PH_CMD1; end
                end
                PH_GAP_OLD_OK: do_detect = 1'b1;
                PH_END_SEL: begin go_fill = 1'b1; fill_ph = PH_END_DESEL; end
                PH_END_DESEL: begin do_finish = 1'b1; fin_st = ST_OK; end
                PH_RD_PRE: begin go_cmd = 1'b1; cmd_ph = PH_CMD17; new_arg = arg_q; end
                PH_RD_TAIL_OK: begin do_finish = 1'b1; fin_st = ST_OK; end
                default: begin do_finish = 1'b1; fin_st = ST_FAIL; end
              endcase
            end
          end
        end
      end
      default: ;
    endcase

    // capacity detected: selected end or CMD16
    if (do_detect) begin
      sdhc_d = det_v;
      if (det_v) begin go_fill = 1'b1; fill_ph = PH_END_SEL; end
      else begin go_cmd = 1'b1; cmd_ph = PH_CMD16; new_arg = 32'd1; end
    end

    nx_code = cmd_code(cmd_ph);
    if (go_cmd) begin
      phase_d = cmd_ph;
      arg_d = sdhc_d ? new_arg : (new_arg << 9);
      bidx_d = 8'd1; poll_d = '0;
      r.tx_valid = 1'b1; r.tx_byte = nx_code[7:0];
    end
    if (go_fill) begin
      phase_d = fill_ph; bidx_d = 8'd1; wasm_d = '0;
      r.tx_valid = 1'b1; r.tx_byte = BYTE_IDLE;
    end
    if (do_finish) begin
      phase_d = PH_IDLE; r.tx_valid = 1'b0; r.tx_byte = '0; r.status = fin_st;
    end

    r.chip_select = !(phase_d == PH_IDLE || phase_d == PH_SPIN_RST ||
                      phase_d == PH_END_DESEL || phase_d == PH_RD_PRE);
    r.fast_clock = (phase_d >= PH_CMD17);
    r.card_is_sdhc = sdhc_d;
  end

  assign rsp_o = r;

  `ASSERT_IMPL(a_tx_zero, clk_i, rst_ni, !rsp_o.tx_valid, rsp_o.tx_byte == 8'd0)
  `ASSERT_IMPL(a_last_dv, clk_i, rst_ni, rsp_o.last_word, rsp_o.data_valid)
  `ASSERT_IMPL(a_done_idle, clk_i, rst_ni, rsp_o.status != ST_BUSY,
               !rsp_o.tx_valid && !rsp_o.chip_select)
endmodule
`default_nettype wire

### hdl/sd_card_spi_host_sequencer.sv
// An accepted request word's result is registered in the output register, or in the skid word.
// Throughput: one word per cycle while the skid word is free; the state update is a single pass.
// A skid word keeps the input open for one more word while a result waits.
// Reset: asynchronous, active low; idle phase, counters zero, limits at defaults.
// ----------------------------------------------------------------------------
// sd_card_spi_host_sequencer
// SPI-mode SD card host: init and sector read, one SPI byte per step.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sd_card_spi_host_sequencer #(
  parameter int unsigned SECTOR_WORDS = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [20:0] cfg_data_i,
  sdspi_stream_if.sink     req_if,
  sdspi_stream_if.source   rsp_if
);
  import sdspi_pkg::*;

  cfg_t cfg;
  rsp_t step_rsp;
  logic acc;
  logic out_v_q, skid_v_q;
  rsp_t out_q, skid_q;

  assign req_if.ready = !skid_v_q;
  assign acc = req_if.valid && req_if.ready;

  sdspi_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i, .cfg_o(cfg)
  );

  sdspi_core #(.SECTOR_WORDS(SECTOR_WORDS)) u_core (
    .clk_i, .rst_ni, .cfg_i(cfg), .req_valid_i(acc), .req_i(req_if.data),
    .rsp_o(step_rsp)
  );

  // output register with skid word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0; skid_v_q <= 1'b0;
    end else begin
      if (!out_v_q || rsp_if.ready) begin
        out_v_q  <= skid_v_q || acc;
        skid_v_q <= 1'b0;
      end else if (acc) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || rsp_if.ready) out_q <= skid_v_q ? skid_q : step_rsp;
    else if (acc) skid_q <= step_rsp;
  end

  assign rsp_if.valid = out_v_q;
  assign rsp_if.data  = out_q;

  `ASSERT_NEXT(a_skid_hold, clk_i, rst_ni, skid_v_q && !rsp_if.ready, skid_v_q)
  `ASSERT_IMPL(a_skid_out, clk_i, rst_ni, skid_v_q, out_v_q)
  `ASSERT_NEXT(a_acc_out, clk_i, rst_ni, acc, out_v_q)
endmodule
`default_nettype wire
